// ===== rtl/mid_pkg.sv =====
package mid_pkg;

	// label store geometry
	localparam int LABEL_SLOTS = 128;
	localparam int IDX_W       = (LABEL_SLOTS > 1) ? $clog2(LABEL_SLOTS) : 1;
	localparam int SLOT_W      = 7;

	// input item kinds (tuser)
	localparam logic IN_LOAD   = 1'b0;
	localparam logic IN_DECODE = 1'b1;

	// instruction formats
	localparam logic [1:0] FMT_R = 2'd0;
	localparam logic [1:0] FMT_I = 2'd1;
	localparam logic [1:0] FMT_J = 2'd2;

	// operation codes
	localparam logic [4:0] OP_UNKNOWN = 5'd0;
	localparam logic [4:0] OP_ADD     = 5'd1;
	localparam logic [4:0] OP_SUB     = 5'd2;
	localparam logic [4:0] OP_AND     = 5'd3;
	localparam logic [4:0] OP_NOR     = 5'd4;
	localparam logic [4:0] OP_SLL     = 5'd5;
	localparam logic [4:0] OP_SRL     = 5'd6;
	localparam logic [4:0] OP_JR      = 5'd7;
	localparam logic [4:0] OP_MULT    = 5'd8;
	localparam logic [4:0] OP_DIV     = 5'd9;
	localparam logic [4:0] OP_MFLO    = 5'd10;
	localparam logic [4:0] OP_MFHI    = 5'd11;
	localparam logic [4:0] OP_BEQ     = 5'd12;
	localparam logic [4:0] OP_BNE     = 5'd13;
	localparam logic [4:0] OP_ADDI    = 5'd14;
	localparam logic [4:0] OP_ADDIU   = 5'd15;
	localparam logic [4:0] OP_ANDI    = 5'd16;
	localparam logic [4:0] OP_ORI     = 5'd17;
	localparam logic [4:0] OP_SLTI    = 5'd18;
	localparam logic [4:0] OP_SLTIU   = 5'd19;
	localparam logic [4:0] OP_LW      = 5'd20;
	localparam logic [4:0] OP_SW      = 5'd21;
	localparam logic [4:0] OP_J       = 5'd22;
	localparam logic [4:0] OP_JAL     = 5'd23;

	// primary opcode field values
	localparam logic [5:0] OPC_RTYPE = 6'b000000;
	localparam logic [5:0] OPC_J     = 6'b000010;
	localparam logic [5:0] OPC_JAL   = 6'b000011;
	localparam logic [5:0] OPC_BEQ   = 6'b000100;
	localparam logic [5:0] OPC_BNE   = 6'b000101;
	localparam logic [5:0] OPC_ADDI  = 6'b001000;
	localparam logic [5:0] OPC_ADDIU = 6'b001001;
	localparam logic [5:0] OPC_SLTI  = 6'b001010;
	localparam logic [5:0] OPC_SLTIU = 6'b001011;
	localparam logic [5:0] OPC_ANDI  = 6'b001100;
	localparam logic [5:0] OPC_ORI   = 6'b001101;
	localparam logic [5:0] OPC_LW    = 6'b100011;
	localparam logic [5:0] OPC_SW    = 6'b101011;

	// funct field values
	localparam logic [5:0] FN_SLL  = 6'b000000;
	localparam logic [5:0] FN_SRL  = 6'b000010;
	localparam logic [5:0] FN_JR   = 6'b001000;
	localparam logic [5:0] FN_MFHI = 6'b010000;
	localparam logic [5:0] FN_MFLO = 6'b010010;
	localparam logic [5:0] FN_MULT = 6'b011000;
	localparam logic [5:0] FN_DIV  = 6'b011010;
	localparam logic [5:0] FN_ADD  = 6'b100000;
	localparam logic [5:0] FN_SUB  = 6'b100010;
	localparam logic [5:0] FN_AND  = 6'b100100;
	localparam logic [5:0] FN_NOR  = 6'b100111;

	typedef struct packed {
		logic [4:0]         operation;
		logic [1:0]         format;
		logic [4:0]         source_reg;
		logic [4:0]         target_reg;
		logic [4:0]         dest_reg;
		logic [4:0]         shift_amount;
		logic signed [16:0] immediate;
		logic [27:0]        jump_byte_address;
		logic               is_jump;
	} dec_t;

	typedef struct packed {
		logic              done;
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} scan_res_t;

endpackage

// ===== rtl/mid_field_decode.sv =====
module mid_field_decode (
	input  logic [31:0]   word,
	output mid_pkg::dec_t dec
);

	logic [5:0] opc;
	logic [5:0] funct;
	logic [4:0] op_r;
	logic [4:0] op_i;

	assign opc   = word[31:26];
	assign funct = word[5:0];

	always_comb begin
		unique case (funct)
			mid_pkg::FN_ADD:  op_r = mid_pkg::OP_ADD;
			mid_pkg::FN_SUB:  op_r = mid_pkg::OP_SUB;
			mid_pkg::FN_AND:  op_r = mid_pkg::OP_AND;
			mid_pkg::FN_NOR:  op_r = mid_pkg::OP_NOR;
			mid_pkg::FN_SLL:  op_r = mid_pkg::OP_SLL;
			mid_pkg::FN_SRL:  op_r = mid_pkg::OP_SRL;
			mid_pkg::FN_JR:   op_r = mid_pkg::OP_JR;
			mid_pkg::FN_MULT: op_r = mid_pkg::OP_MULT;
			mid_pkg::FN_DIV:  op_r = mid_pkg::OP_DIV;
			mid_pkg::FN_MFLO: op_r = mid_pkg::OP_MFLO;
			mid_pkg::FN_MFHI: op_r = mid_pkg::OP_MFHI;
			default:          op_r = mid_pkg::OP_UNKNOWN;
		endcase
	end

	always_comb begin
		unique case (opc)
			mid_pkg::OPC_BEQ:   op_i = mid_pkg::OP_BEQ;
			mid_pkg::OPC_BNE:   op_i = mid_pkg::OP_BNE;
			mid_pkg::OPC_ADDI:  op_i = mid_pkg::OP_ADDI;
			mid_pkg::OPC_ADDIU: op_i = mid_pkg::OP_ADDIU;
			mid_pkg::OPC_ANDI:  op_i = mid_pkg::OP_ANDI;
			mid_pkg::OPC_ORI:   op_i = mid_pkg::OP_ORI;
			mid_pkg::OPC_SLTI:  op_i = mid_pkg::OP_SLTI;
			mid_pkg::OPC_SLTIU: op_i = mid_pkg::OP_SLTIU;
			mid_pkg::OPC_LW:    op_i = mid_pkg::OP_LW;
			mid_pkg::OPC_SW:    op_i = mid_pkg::OP_SW;
			default:            op_i = mid_pkg::OP_UNKNOWN;
		endcase
	end

	always_comb begin
		dec.source_reg        = word[25:21];
		dec.target_reg        = word[20:16];
		dec.dest_reg          = word[15:11];
		dec.shift_amount      = word[10:6];
		dec.jump_byte_address = 28'd0;
		dec.is_jump           = 1'b0;
		unique case (opc)
			mid_pkg::OPC_RTYPE: begin
				dec.format    = mid_pkg::FMT_R;
				dec.operation = op_r;
			end
			mid_pkg::OPC_J, mid_pkg::OPC_JAL: begin
				dec.format            = mid_pkg::FMT_J;
				dec.operation         = (opc == mid_pkg::OPC_J) ? mid_pkg::OP_J : mid_pkg::OP_JAL;
				dec.jump_byte_address = {word[25:0], 2'b00};
				dec.is_jump           = 1'b1;
			end
			default: begin
				dec.format    = mid_pkg::FMT_I;
				dec.operation = op_i;
			end
		endcase
		// addiu and sltiu take a zero-extended immediate
		if (dec.operation == mid_pkg::OP_ADDIU || dec.operation == mid_pkg::OP_SLTIU) begin
			dec.immediate = {1'b0, word[15:0]};
		end else begin
			dec.immediate = {word[15], word[15:0]};
		end
	end

endmodule

// ===== rtl/mid_label_store.sv =====
module mid_label_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [mid_pkg::SLOT_W-1:0] wr_slot,
	input  logic [31:0]                wr_addr,
	input  logic                       start,
	input  logic [27:0]                jaddr,
	output mid_pkg::scan_res_t         res
);

	localparam logic [mid_pkg::IDX_W-1:0] LAST_IDX = mid_pkg::IDX_W'(mid_pkg::LABEL_SLOTS - 1);

	logic [31:0]                mem [mid_pkg::LABEL_SLOTS];
	logic [mid_pkg::LABEL_SLOTS-1:0] valid_q;

	logic                       scan_active_q;
	logic [mid_pkg::IDX_W-1:0]  addr_q;
	logic                       rd_vld_s1;
	logic [mid_pkg::IDX_W-1:0]  rd_addr_s1;
	logic [31:0]                rd_data_s1;
	logic                       rd_valid_bit_s1;
	logic                       rd_last_s1;

	logic                       wr_in_range;
	logic [mid_pkg::IDX_W-1:0]  wr_idx;
	logic                       match;

	assign wr_in_range = ({25'd0, wr_slot} < 32'(mid_pkg::LABEL_SLOTS));
	assign wr_idx      = mid_pkg::IDX_W'(wr_slot);

	// label addresses: written by load transactions, read one slot a cycle by the scan
	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem[wr_idx] <= wr_addr;
		end
		rd_data_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en && wr_in_range) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	assign match    = rd_vld_s1 && rd_valid_bit_s1 && (rd_data_s1 == {4'd0, jaddr});
	assign res.done = rd_vld_s1 && (match || rd_last_s1);
	assign res.hit  = match;
	assign res.slot = match ? mid_pkg::SLOT_W'(rd_addr_s1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_active_q   <= 1'b0;
			addr_q          <= '0;
			rd_vld_s1       <= 1'b0;
			rd_addr_s1      <= '0;
			rd_valid_bit_s1 <= 1'b0;
			rd_last_s1      <= 1'b0;
		end else begin
			rd_addr_s1      <= addr_q;
			rd_valid_bit_s1 <= valid_q[addr_q];
			rd_last_s1      <= (addr_q == LAST_IDX);
			if (start) begin
				scan_active_q <= 1'b1;
				addr_q        <= '0;
				rd_vld_s1     <= 1'b0;
			end else if (res.done) begin
				// a hit or the last slot ends the scan, drop the read in flight
				scan_active_q <= 1'b0;
				addr_q        <= '0;
				rd_vld_s1     <= 1'b0;
			end else if (scan_active_q) begin
				rd_vld_s1 <= 1'b1;
				if (addr_q == LAST_IDX) begin
					scan_active_q <= 1'b0;
					addr_q        <= '0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end else begin
				rd_vld_s1 <= 1'b0;
			end
		end
	end

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> scan_active_q && !rd_vld_s1)
		else $error("scan not armed after start");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> !scan_active_q && !rd_vld_s1)
		else $error("scan still running after completion");

	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.hit |-> res.done)
		else $error("hit reported outside completion");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.slot != '0) |-> res.hit)
		else $error("non-zero slot without hit");

endmodule

// ===== rtl/mips_instruction_decoder_core.sv =====
// mips32 instruction decoder with a label address store
//
// slave channel (s_*): one transaction per item. s_tuser[0] picks the kind:
//   0 = load: writes label_address into label slot 'slot' and marks it valid;
//       no result transaction follows
//   1 = decode: instruction_word is decoded and one result transaction follows
// master channel (m_*): decoded fields, see the packing beside m_tdata
//
// the block stays idle after a load and can take the next item. a non-jump
// decode passes through the hold state and then into the output register. j
// and jal search the label store one slot per cycle through a memory with a
// registered read, stopping at the first hit or after the last slot. the block
// takes the next transaction once the previous one has been handed to the
// output register.
// reset clears all label valid bits at once, so the store is usable right away;
// the addresses themselves are not cleared. when the receiver stalls, the result
// holds in the output register and the block still accepts one more item; a
// second finished result waits internally and s_tready stays low until the
// output register frees up.
module mips_instruction_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // instruction_word[31:0], slot[38:32], label_address[70:39], zero pad
	input  logic [0:0]  s_tuser,   // item kind: 0 = load, 1 = decode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // operation[4:0], format[6:5], source_reg[11:7],
	                               // target_reg[16:12], dest_reg[21:17], shift_amount[26:22],
	                               // immediate[43:27], jump_byte_address[71:44],
	                               // label_hit[72], label_slot[79:73]
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]                  state_q;
	mid_pkg::dec_t               dec_in;
	mid_pkg::dec_t               dec_q;
	logic                        hit_q;
	logic [mid_pkg::SLOT_W-1:0]  lslot_q;
	logic                        m_tvalid_q;
	logic [79:0]                 m_tdata_q;
	mid_pkg::scan_res_t          scan_res;

	logic accept;
	logic is_decode;
	logic out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign is_decode = (s_tuser[0] == mid_pkg::IN_DECODE);
	assign out_free  = !m_tvalid_q || m_tready;

	mid_field_decode u_decode (
		.word (s_tdata[31:0]),
		.dec  (dec_in)
	);

	mid_label_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && !is_decode),
		.wr_slot (s_tdata[38:32]),
		.wr_addr (s_tdata[70:39]),
		.start   (accept && is_decode && dec_in.is_jump),
		.jaddr   (dec_q.jump_byte_address),
		.res     (scan_res)
	);

	// decoded fields of the item in flight
	always_ff @(posedge clk) begin
		if (accept && is_decode) begin
			dec_q <= dec_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hit_q      <= 1'b0;
			lslot_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// output valid: set when a finished item moves out, cleared once taken
			if (state_q == ST_HOLD && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_decode) begin
						hit_q   <= 1'b0;
						lslot_q <= '0;
						state_q <= dec_in.is_jump ? ST_SCAN : ST_HOLD;
					end
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						hit_q   <= scan_res.hit;
						lslot_q <= scan_res.slot;
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register, loaded when the finished item moves out
	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			m_tdata_q <= {lslot_q, hit_q, dec_q.jump_byte_address, dec_q.immediate,
				dec_q.shift_amount, dec_q.dest_reg, dec_q.target_reg, dec_q.source_reg,
				dec_q.format, dec_q.operation};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== dv/mips_instruction_decoder_core_tb.sv =====
`timescale 1ns / 100ps

module mips_instruction_decoder_core_tb;

	localparam int          RANDOM_ITEMS = 420;
	localparam int          KNOWN_OPS    = 21;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          WANT_DEPTH   = 64;
	// opcode and funct values that name no operation
	localparam logic [5:0]  OPC_UNUSED   = 6'b111111;
	localparam logic [5:0]  FN_UNUSED    = 6'b111111;

	// one decode result, laid out as on m_tdata (msb first)
	typedef struct packed {
		logic [mid_pkg::SLOT_W-1:0] label_slot;
		logic                       label_hit;
		logic [27:0]                jump_byte_address;
		logic signed [16:0]         immediate;
		logic [4:0]                 shift_amount, dest_reg, target_reg, source_reg;
		logic [1:0]                 format;
		logic [4:0]                 operation;
	} decode_result_t;

	// decoder behaviour with its own copy of the label store
	class decode_checker;
		logic [31:0]    label_addr_copy [mid_pkg::LABEL_SLOTS];
		bit             label_valid_copy [mid_pkg::LABEL_SLOTS];
		decode_result_t want_fifo [WANT_DEPTH];
		int unsigned    want_wr;
		int unsigned    want_rd;
		int unsigned    mismatches;

		function int unsigned outstanding();
			return want_wr - want_rd;
		endfunction

		function string describe(decode_result_t r);
			return $sformatf({"op=%0d fmt=%0d rs=%0d rt=%0d rd=%0d sh=%0d imm=%h",
				" jaddr=%h hit=%0d slot=%0d"},
				r.operation, r.format, r.source_reg, r.target_reg, r.dest_reg, r.shift_amount,
				r.immediate, r.jump_byte_address, r.label_hit, r.label_slot);
		endfunction

		// called for every accepted input transaction, in order
		function void accept_item(logic kind, logic [31:0] word, logic [6:0] slot,
				logic [31:0] addr);
			decode_result_t r;
			int i;
			if (kind == mid_pkg::IN_LOAD) begin
				if (slot < mid_pkg::LABEL_SLOTS) begin
					label_addr_copy[slot]  = addr;
					label_valid_copy[slot] = 1'b1;
				end
				return;
			end
			r = '0;
			r.source_reg   = word[25:21];
			r.target_reg   = word[20:16];
			r.dest_reg     = word[15:11];
			r.shift_amount = word[10:6];
			case (word[31:26])
				mid_pkg::OPC_RTYPE: begin
					r.format = mid_pkg::FMT_R;
					case (word[5:0])
						mid_pkg::FN_ADD:  r.operation = mid_pkg::OP_ADD;
						mid_pkg::FN_SUB:  r.operation = mid_pkg::OP_SUB;
						mid_pkg::FN_AND:  r.operation = mid_pkg::OP_AND;
						mid_pkg::FN_NOR:  r.operation = mid_pkg::OP_NOR;
						mid_pkg::FN_SLL:  r.operation = mid_pkg::OP_SLL;
						mid_pkg::FN_SRL:  r.operation = mid_pkg::OP_SRL;
						mid_pkg::FN_JR:   r.operation = mid_pkg::OP_JR;
						mid_pkg::FN_MULT: r.operation = mid_pkg::OP_MULT;
						mid_pkg::FN_DIV:  r.operation = mid_pkg::OP_DIV;
						mid_pkg::FN_MFLO: r.operation = mid_pkg::OP_MFLO;
						mid_pkg::FN_MFHI: r.operation = mid_pkg::OP_MFHI;
						default:          r.operation = mid_pkg::OP_UNKNOWN;
					endcase
				end
				mid_pkg::OPC_J, mid_pkg::OPC_JAL: begin
					r.format            = mid_pkg::FMT_J;
					r.operation         = (word[31:26] == mid_pkg::OPC_J) ? mid_pkg::OP_J
					                                                      : mid_pkg::OP_JAL;
					r.jump_byte_address = {word[25:0], 2'b00};
					// lowest valid slot holding the byte target wins
					for (i = 0; i < mid_pkg::LABEL_SLOTS && !r.label_hit; i++) begin
						if (label_valid_copy[i] &&
								label_addr_copy[i] == {4'h0, r.jump_byte_address}) begin
							r.label_hit  = 1'b1;
							r.label_slot = i[mid_pkg::SLOT_W-1:0];
						end
					end
				end
				default: begin
					r.format = mid_pkg::FMT_I;
					case (word[31:26])
						mid_pkg::OPC_BEQ:   r.operation = mid_pkg::OP_BEQ;
						mid_pkg::OPC_BNE:   r.operation = mid_pkg::OP_BNE;
						mid_pkg::OPC_ADDI:  r.operation = mid_pkg::OP_ADDI;
						mid_pkg::OPC_ADDIU: r.operation = mid_pkg::OP_ADDIU;
						mid_pkg::OPC_ANDI:  r.operation = mid_pkg::OP_ANDI;
						mid_pkg::OPC_ORI:   r.operation = mid_pkg::OP_ORI;
						mid_pkg::OPC_SLTI:  r.operation = mid_pkg::OP_SLTI;
						mid_pkg::OPC_SLTIU: r.operation = mid_pkg::OP_SLTIU;
						mid_pkg::OPC_LW:    r.operation = mid_pkg::OP_LW;
						mid_pkg::OPC_SW:    r.operation = mid_pkg::OP_SW;
						default:            r.operation = mid_pkg::OP_UNKNOWN;
					endcase
				end
			endcase
			// only addiu and sltiu zero-extend, branch offsets included in the signed set
			if (r.operation == mid_pkg::OP_ADDIU || r.operation == mid_pkg::OP_SLTIU)
				r.immediate = {1'b0, word[15:0]};
			else
				r.immediate = {word[15], word[15:0]};
			want_fifo[want_wr % WANT_DEPTH] = r;
			want_wr++;
		endfunction

		function void check_result(decode_result_t got);
			decode_result_t want;
			string          bad;
			if (outstanding() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %s", describe(got));
				return;
			end
			want = want_fifo[want_rd % WANT_DEPTH];
			want_rd++;
			bad  = "";
			if (got.operation !== want.operation)                 bad = {bad, " operation"};
			if (got.format !== want.format)                       bad = {bad, " format"};
			if (got.source_reg !== want.source_reg)               bad = {bad, " source_reg"};
			if (got.target_reg !== want.target_reg)               bad = {bad, " target_reg"};
			if (got.dest_reg !== want.dest_reg)                   bad = {bad, " dest_reg"};
			if (got.shift_amount !== want.shift_amount)           bad = {bad, " shift_amount"};
			if (got.immediate !== want.immediate)                 bad = {bad, " immediate"};
			if (got.jump_byte_address !== want.jump_byte_address) bad = {bad, " jump_byte_address"};
			if (got.label_hit !== want.label_hit)                 bad = {bad, " label_hit"};
			if (got.label_slot !== want.label_slot)               bad = {bad, " label_slot"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("wrong field(s):%s", bad);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;

	decode_checker chk;
	bit            s_steady, m_steady;
	int            stall_left, phase_left;
	int            cycle_count;

	mips_instruction_decoder_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
		                                   : int'($urandom_range(1, 3));
	endfunction

	// overlays the opcode (and funct) of known operation k onto a word
	function automatic logic [31:0] with_known_op(int k, logic [31:0] w);
		logic [31:0] r;
		r = w;
		case (k)
			0:  {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_ADD};
			1:  {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_SUB};
			2:  {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_AND};
			3:  {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_NOR};
			4:  {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_SLL};
			5:  {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_SRL};
			6:  {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_JR};
			7:  {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_MULT};
			8:  {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_DIV};
			9:  {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_MFLO};
			10: {r[31:26], r[5:0]} = {mid_pkg::OPC_RTYPE, mid_pkg::FN_MFHI};
			11: r[31:26] = mid_pkg::OPC_BEQ;
			12: r[31:26] = mid_pkg::OPC_BNE;
			13: r[31:26] = mid_pkg::OPC_ADDI;
			14: r[31:26] = mid_pkg::OPC_ADDIU;
			15: r[31:26] = mid_pkg::OPC_ANDI;
			16: r[31:26] = mid_pkg::OPC_ORI;
			17: r[31:26] = mid_pkg::OPC_SLTI;
			18: r[31:26] = mid_pkg::OPC_SLTIU;
			19: r[31:26] = mid_pkg::OPC_LW;
			default: r[31:26] = mid_pkg::OPC_SW;
		endcase
		return r;
	endfunction

	// label addresses: mostly reachable jump targets, some duplicates, some anything
	function automatic logic [31:0] random_label_addr();
		logic [31:0] w;
		int          s;
		w = $urandom();
		s = $urandom_range(0, mid_pkg::LABEL_SLOTS - 1);
		case ($urandom_range(0, 9))
			0, 1:    return w;
			2:       return chk.label_valid_copy[s] ? chk.label_addr_copy[s] : w;
			default: return {4'h0, w[27:2], 2'b00};
		endcase
	endfunction

	// one input transaction, optionally after an idle gap
	task automatic send_item(logic kind, logic [31:0] word, logic [6:0] slot,
			logic [31:0] addr);
		int gap;
		gap = (!s_steady && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {1'b0, addr, slot, word};
		do @(posedge clk); while (!s_tready);
		chk.accept_item(kind, word, slot, addr);
	endtask

	// receiver: random stalls, with stretches of steady acceptance
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			chk.check_result(m_tdata);
		if (phase_left == 0) begin
			m_steady   = ($urandom_range(0, 3) == 0);
			phase_left = $urandom_range(50, 300);
		end else begin
			phase_left--;
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!m_steady && $urandom_range(0, 3) == 0) begin
			m_tready   <= 1'b0;
			stall_left = gap_len() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("mips_instruction_decoder_core: mismatch");
			$finish;
		end
	end

	initial begin
		int          k, n, s;
		logic [31:0] a, w;
		logic [5:0]  opc;
		chk = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: two labels, then every operation at field extremes
		send_item(mid_pkg::IN_LOAD, $urandom(), 7'd0, 32'h0000_1234);
		send_item(mid_pkg::IN_LOAD, $urandom(), 7'd1, 32'h0FFF_FFFC);
		send_item(mid_pkg::IN_DECODE, 32'h0000_0000, 7'($urandom_range(0, 127)), $urandom());
		for (k = 0; k < KNOWN_OPS; k++)
			send_item(mid_pkg::IN_DECODE,
				with_known_op(k, k[0] ? 32'hFFFF_FFFF : 32'h0000_8000),
				7'($urandom_range(0, 127)), $urandom());
		// unknown funct and unknown opcode still give format and sign-extended immediate
		send_item(mid_pkg::IN_DECODE, {mid_pkg::OPC_RTYPE, 20'hFFFFF, FN_UNUSED}, 7'd127,
			32'hFFFF_FFFF);
		send_item(mid_pkg::IN_DECODE, {OPC_UNUSED, 26'h000_8000}, 7'd0, 32'h0);
		// jumps that only scan slots already written
		send_item(mid_pkg::IN_DECODE, {mid_pkg::OPC_J, 26'h000_048D},
			7'($urandom_range(0, 127)), $urandom());
		send_item(mid_pkg::IN_DECODE, {mid_pkg::OPC_JAL, 26'h3FF_FFFF},
			7'($urandom_range(0, 127)), $urandom());

		// fill every slot so that later scans never touch an unwritten entry
		for (n = 0; n < mid_pkg::LABEL_SLOTS; n++) begin
			if (n == mid_pkg::LABEL_SLOTS - 1)      a = 32'hFFFF_FFFF;
			else if (n == mid_pkg::LABEL_SLOTS - 2) a = 32'h0000_0000;
			else                                    a = random_label_addr();
			send_item(mid_pkg::IN_LOAD, $urandom(), 7'(n), a);
		end

		// random mix of loads, jumps, known operations and arbitrary words
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				s_steady = ($urandom_range(0, 3) == 0);
			k = $urandom_range(0, 99);
			if (k < 30) begin
				send_item(mid_pkg::IN_LOAD, $urandom(), 7'($urandom_range(0, 127)),
					random_label_addr());
			end else if (k < 55) begin
				// jump mostly aimed at a stored label, else at a random target
				s   = $urandom_range(0, mid_pkg::LABEL_SLOTS - 1);
				a   = chk.label_addr_copy[s];
				opc = $urandom_range(0, 1) ? mid_pkg::OPC_J : mid_pkg::OPC_JAL;
				w   = $urandom();
				if (chk.label_valid_copy[s] && a[31:28] == 4'h0 && a[1:0] == 2'b00 &&
						$urandom_range(0, 9) < 7)
					w[25:0] = a[27:2];
				send_item(mid_pkg::IN_DECODE, {opc, w[25:0]}, 7'($urandom_range(0, 127)),
					$urandom());
			end else if (k < 85) begin
				send_item(mid_pkg::IN_DECODE,
					with_known_op($urandom_range(0, KNOWN_OPS - 1), $urandom()),
					7'($urandom_range(0, 127)), $urandom());
			end else begin
				send_item(mid_pkg::IN_DECODE, $urandom(), 7'($urandom_range(0, 127)),
					$urandom());
			end
		end
		s_tvalid <= 1'b0;

		// drain, then give any stray transaction time to show up
		while (chk.outstanding() != 0) @(posedge clk);
		repeat (2 * mid_pkg::LABEL_SLOTS) @(posedge clk);
		if (chk.mismatches == 0)
			$display("mips_instruction_decoder_core: match");
		else
			$display("mips_instruction_decoder_core: mismatch");
		$finish;
	end

endmodule
